>>> sv/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Holds field widths, operation codes and the task table record types.
// No dependencies; imported by every module of the block.
package pps_pkg;

    localparam int TIME_W             = 16;
    localparam int PRIO_W             = 8;
    localparam int SLOT_W             = 3;
    localparam int DEFAULT_TASK_SLOTS = 8;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] arrive;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] work;
    } entry_t;

    typedef struct packed {
        logic load_we;
        logic work_we;
    } tbl_wr_t;

endpackage

>>> sv/pps_table.sv
// Task table of the preemptive priority scheduler: arrival, burst, priority
// and work-left memories with one registered read port and one write port.
// Depends on pps_pkg; a per-slot flag marks slots with work left.
module pps_table #(
    parameter int TASK_SLOTS = pps_pkg::DEFAULT_TASK_SLOTS,
    parameter int ADDR_W     = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output pps_pkg::entry_t  rd_data,
    output logic             rd_busy,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pps_pkg::tbl_wr_t wr_ctl,
    input  pps_pkg::entry_t  wr_data,
    output logic             none_busy
);
    import pps_pkg::*;

    logic [TIME_W-1:0] arrive_mem [TASK_SLOTS];
    logic [TIME_W-1:0] burst_mem  [TASK_SLOTS];
    logic [PRIO_W-1:0] prio_mem   [TASK_SLOTS];
    logic [TIME_W-1:0] work_mem   [TASK_SLOTS];

    entry_t                rd_data_reg;
    logic                  rd_busy_reg;
    logic [TASK_SLOTS-1:0] busy_reg;
    logic [TASK_SLOTS-1:0] busy_next;

    always_comb
    begin
        busy_next = busy_reg;
        if (wr_ctl.load_we || wr_ctl.work_we)
        begin
            busy_next[wr_addr] = (wr_data.work != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.load_we)
        begin
            arrive_mem[wr_addr] <= wr_data.arrive;
            burst_mem[wr_addr]  <= wr_data.burst;
            prio_mem[wr_addr]   <= wr_data.prio;
        end
        if (wr_ctl.load_we || wr_ctl.work_we)
        begin
            work_mem[wr_addr] <= wr_data.work;
        end
        rd_data_reg.arrive <= arrive_mem[rd_addr];
        rd_data_reg.burst  <= burst_mem[rd_addr];
        rd_data_reg.prio   <= prio_mem[rd_addr];
        rd_data_reg.work   <= work_mem[rd_addr];
        rd_busy_reg        <= busy_reg[rd_addr];
    end

    assign rd_data   = rd_data_reg;
    assign rd_busy   = rd_busy_reg;
    assign none_busy = ~|busy_reg;

endmodule

>>> sv/pps_ctrl.sv
// Sequencer of the preemptive priority scheduler: scans the task table through
// one shared compare unit, updates the chosen task and the clock, and reports.
// Depends on pps_pkg and drives the ports of pps_table.
module pps_ctrl #(
    parameter int TASK_SLOTS = pps_pkg::DEFAULT_TASK_SLOTS,
    parameter int ADDR_W     = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [pps_pkg::SLOT_W-1:0]    slot,
    input  logic [pps_pkg::TIME_W-1:0]    arrive_time,
    input  logic [pps_pkg::TIME_W-1:0]    burst_length,
    input  logic [pps_pkg::PRIO_W-1:0]    task_priority,
    output logic                          done,
    output logic                          idle,
    output logic [pps_pkg::SLOT_W-1:0]    running_slot,
    output logic                          finished,
    output logic [pps_pkg::TIME_W-1:0]    finish_time,
    output logic [pps_pkg::TIME_W-1:0]    turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]    wait_time,
    output logic                          all_done,
    output logic [ADDR_W-1:0]             rd_addr,
    input  pps_pkg::entry_t               rd_data,
    input  logic                          rd_busy,
    output logic [ADDR_W-1:0]             wr_addr,
    output pps_pkg::tbl_wr_t              wr_ctl,
    output pps_pkg::entry_t               wr_data,
    input  logic                          none_busy
);
    import pps_pkg::*;

    localparam int CNT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS + 1) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              found_reg, found_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              done_reg, done_next;

    logic [ADDR_W-1:0] best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [TIME_W-1:0] best_arrive_reg, best_arrive_next;
    logic [TIME_W-1:0] best_burst_reg, best_burst_next;
    logic [TIME_W-1:0] best_work_reg, best_work_next;
    logic              fin_reg, fin_next;
    logic [TIME_W-1:0] tat_reg, tat_next;

    logic              idle_reg, idle_next;
    logic [SLOT_W-1:0] run_slot_reg, run_slot_next;
    logic              finished_reg, finished_next;
    logic [TIME_W-1:0] finish_time_reg, finish_time_next;
    logic [TIME_W-1:0] tat_out_reg, tat_out_next;
    logic [TIME_W-1:0] wait_out_reg, wait_out_next;
    logic              all_done_reg, all_done_next;

    logic              slot_ok;
    logic              cand;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] tat_calc;
    logic [TIME_W-1:0] wait_calc;

    assign slot_ok   = (32'(slot) < TASK_SLOTS);
    assign cand      = pend_reg && rd_busy && (rd_data.arrive <= time_reg)
                       && (!found_reg || (rd_data.prio < best_prio_reg));
    assign time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + 16'd1;
    assign tat_calc  = time_inc - best_arrive_reg;
    assign wait_calc = (tat_reg > best_burst_reg) ? tat_reg - best_burst_reg : '0;

    always_comb
    begin
        state_next       = state_reg;
        scan_cnt_next    = scan_cnt_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        found_next       = found_reg;
        time_next        = time_reg;
        done_next        = 1'b0;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_arrive_next = best_arrive_reg;
        best_burst_next  = best_burst_reg;
        best_work_next   = best_work_reg;
        fin_next         = fin_reg;
        tat_next         = tat_reg;
        idle_next        = idle_reg;
        run_slot_next    = run_slot_reg;
        finished_next    = finished_reg;
        finish_time_next = finish_time_reg;
        tat_out_next     = tat_out_reg;
        wait_out_next    = wait_out_reg;
        all_done_next    = all_done_reg;

        rd_addr        = scan_cnt_reg[ADDR_W-1:0];
        wr_ctl         = '0;
        wr_addr        = best_idx_reg;
        wr_data.arrive = best_arrive_reg;
        wr_data.burst  = best_burst_reg;
        wr_data.prio   = best_prio_reg;
        wr_data.work   = best_work_reg - 16'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_LOAD)
                    begin
                        wr_ctl.load_we = slot_ok;
                        wr_addr        = ADDR_W'(slot);
                        wr_data.arrive = arrive_time;
                        wr_data.burst  = burst_length;
                        wr_data.prio   = task_priority;
                        wr_data.work   = burst_length;
                    end
                    else
                    begin
                        state_next    = ST_SCAN;
                        scan_cnt_next = '0;
                        pend_next     = 1'b0;
                        found_next    = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cand)
                begin
                    found_next       = 1'b1;
                    best_idx_next    = pend_idx_reg;
                    best_prio_next   = rd_data.prio;
                    best_arrive_next = rd_data.arrive;
                    best_burst_next  = rd_data.burst;
                    best_work_next   = rd_data.work;
                end
                if (scan_cnt_reg < CNT_W'(TASK_SLOTS))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_cnt_reg[ADDR_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                time_next      = time_inc;
                wr_ctl.work_we = found_reg;
                fin_next       = found_reg && (best_work_reg == 16'd1);
                tat_next       = tat_calc;
                state_next     = ST_REPORT;
            end
            ST_REPORT:
            begin
                done_next        = 1'b1;
                idle_next        = !found_reg;
                run_slot_next    = found_reg ? SLOT_W'(best_idx_reg) : '0;
                finished_next    = fin_reg;
                finish_time_next = time_reg;
                tat_out_next     = fin_reg ? tat_reg : '0;
                wait_out_next    = fin_reg ? wait_calc : '0;
                all_done_next    = none_busy;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            found_reg    <= 1'b0;
            time_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
            found_reg    <= found_next;
            time_reg     <= time_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_prio_reg   <= best_prio_next;
        best_arrive_reg <= best_arrive_next;
        best_burst_reg  <= best_burst_next;
        best_work_reg   <= best_work_next;
        fin_reg         <= fin_next;
        tat_reg         <= tat_next;
        idle_reg        <= idle_next;
        run_slot_reg    <= run_slot_next;
        finished_reg    <= finished_next;
        finish_time_reg <= finish_time_next;
        tat_out_reg     <= tat_out_next;
        wait_out_reg    <= wait_out_next;
        all_done_reg    <= all_done_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign idle            = idle_reg;
    assign running_slot    = run_slot_reg;
    assign finished        = finished_reg;
    assign finish_time     = finish_time_reg;
    assign turnaround_time = tat_out_reg;
    assign wait_time       = wait_out_reg;
    assign all_done        = all_done_reg;

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_REPORT)
        else $error("Result strobe without a report step.");

    a_finish_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && finished_reg |-> !idle_reg)
        else $error("Finished task reported on an idle tick.");

    a_unfinished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !finished_reg |-> tat_out_reg == '0 && wait_out_reg == '0)
        else $error("Times reported for a task that did not finish.");

    a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=>
            (time_reg == $past(time_reg) || time_reg == $past(time_reg) + 16'd1))
        else $error("Current time moved by more than one unit.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(TASK_SLOTS))
        else $error("Scan counter ran past the table.");

endmodule

>>> sv/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg, pps_table and pps_ctrl.
//
// A load transfer (operation 0) writes one task slot in the accepting cycle and
// keeps busy low, so another transfer may follow at once; loads to slots at or
// above TASK_SLOTS are dropped. A tick transfer (operation 1) raises busy, and done
// pulses for one cycle in the first cycle in which busy is low again; the length
// of the busy phase is set by the scan of the task table through
// its single read port, one slot per cycle, followed by an update and a report
// step. The receiver cannot stall: the result is valid only in the cycle done is
// high, and a new transfer may be started in that same cycle.
module preemptive_priority_scheduler #(
    parameter int TASK_SLOTS = pps_pkg::DEFAULT_TASK_SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       operation,
    input  logic [pps_pkg::SLOT_W-1:0] slot,
    input  logic [pps_pkg::TIME_W-1:0] arrive_time,
    input  logic [pps_pkg::TIME_W-1:0] burst_length,
    input  logic [pps_pkg::PRIO_W-1:0] task_priority,
    output logic                       done,
    output logic                       idle,
    output logic [pps_pkg::SLOT_W-1:0] running_slot,
    output logic                       finished,
    output logic [pps_pkg::TIME_W-1:0] finish_time,
    output logic [pps_pkg::TIME_W-1:0] turnaround_time,
    output logic [pps_pkg::TIME_W-1:0] wait_time,
    output logic                       all_done
);
    import pps_pkg::*;

    localparam int ADDR_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              rd_busy;
    logic [ADDR_W-1:0] wr_addr;
    tbl_wr_t           wr_ctl;
    entry_t            wr_data;
    logic              none_busy;

    pps_table #(
        .TASK_SLOTS (TASK_SLOTS),
        .ADDR_W     (ADDR_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rd_busy   (rd_busy),
        .wr_addr   (wr_addr),
        .wr_ctl    (wr_ctl),
        .wr_data   (wr_data),
        .none_busy (none_busy)
    );

    pps_ctrl #(
        .TASK_SLOTS (TASK_SLOTS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .slot            (slot),
        .arrive_time     (arrive_time),
        .burst_length    (burst_length),
        .task_priority   (task_priority),
        .done            (done),
        .idle            (idle),
        .running_slot    (running_slot),
        .finished        (finished),
        .finish_time     (finish_time),
        .turnaround_time (turnaround_time),
        .wait_time       (wait_time),
        .all_done        (all_done),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .rd_busy         (rd_busy),
        .wr_addr         (wr_addr),
        .wr_ctl          (wr_ctl),
        .wr_data         (wr_data),
        .none_busy       (none_busy)
    );

endmodule
